// File: rtl/crcv_pkg.sv
// ----------------------------------------------------------------------------
// crcv_pkg
// Shared widths, codes, reset values and helpers for the circle raster canvas.
// ----------------------------------------------------------------------------
package crcv_pkg;

    localparam int MAX_SIDE_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;

    localparam int COORD_W    = 19;
    localparam int CHAR_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_DRAW  = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_BAD_CIRCLE = 2'd1,
        STAT_OUTSIDE    = 2'd2
    } status_t;

    localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h63;
    localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h43;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 2'd2;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd256;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd256;
    localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

    // One sweep job: clear fills with paint unconditionally, draw tests each cell
    typedef struct packed {
        logic                      clear;
        logic                      outline;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] r;
        logic [CHAR_W-1:0]         paint;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } sweep_cmd_t;

    // Clamp a side register to 1..max_side
    function automatic logic [SIZE_W-1:0] eff_side(input logic [SIZE_W-1:0] v,
                                                   input int max_side);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v == '0)
            res = SIZE_W'(1);
        else if (int'(v) > max_side)
            res = SIZE_W'(max_side);
        return res;
    endfunction

endpackage

// File: rtl/crcv_if.sv
// ----------------------------------------------------------------------------
// crcv_req_if / crcv_rsp_if
// Valid/ready channels carrying request and result words of the canvas.
// ----------------------------------------------------------------------------
interface crcv_req_if
    import crcv_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic [CHAR_W-1:0]         shape_type;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] radius;
    logic [CHAR_W-1:0]         paint_char;
    logic [POS_W-1:0]          read_col;
    logic [POS_W-1:0]          read_row;

    modport source (
        output valid, mode, shape_type, center_x, center_y, radius,
               paint_char, read_col, read_row,
        input  ready
    );
    modport sink (
        input  valid, mode, shape_type, center_x, center_y, radius,
               paint_char, read_col, read_row,
        output ready
    );
endinterface

interface crcv_rsp_if
    import crcv_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAR_W-1:0]   cell_value;

    modport source (
        output valid, status, cell_value,
        input  ready
    );
    modport sink (
        input  valid, status, cell_value,
        output ready
    );
endinterface

// File: rtl/crcv_canvas_mem.sv
// ----------------------------------------------------------------------------
// crcv_canvas_mem
// Byte canvas store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crcv_canvas_mem
    import crcv_pkg::*;
#(
    parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
    parameter int AW    = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CHAR_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [CHAR_W-1:0] rd_data
);

    logic [CHAR_W-1:0] mem_array [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_array[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/crcv_sweep.sv
// ----------------------------------------------------------------------------
// crcv_sweep
// Walks the canvas one cell per cycle within a row, squares offsets on a shared
// squarer and writes painted cells to the canvas store through a short pipeline.
// ----------------------------------------------------------------------------
module crcv_sweep
    import crcv_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int AW        = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sweep_cmd_t        cmd,
    output logic              done,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [CHAR_W-1:0] wr_data
);

    localparam int SIDE_CAP = (MAX_SIDE < 511) ? MAX_SIDE : 511;
    localparam int CW       = (SIDE_CAP > 1) ? $clog2(SIDE_CAP) : 1;
    localparam int PW       = (CW + FRAC_BITS + 1 > COORD_W) ? CW + FRAC_BITS + 1 : COORD_W;
    localparam int DW       = PW + 1;
    localparam int AB       = DW - 1;
    localparam int QW       = 2 * AB;

    typedef enum logic [2:0] {
        S_IDLE, S_R2, S_RM2, S_ROW, S_CELLS, S_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        K_R2, K_RM2, K_DY, K_CELL
    } kind_t;

    state_t     state_reg;
    sweep_cmd_t cmd_reg;
    logic [CW-1:0] row_reg, col_reg;
    logic [AW-1:0] base_reg;
    logic          done_reg;

    logic          s1_valid_reg;
    kind_t         s1_kind_reg;
    logic [QW-1:0] s1_sq_reg;
    logic [AW-1:0] s1_addr_reg;

    logic          s2_valid_reg;
    logic [QW:0]   s2_d2_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [QW-1:0] r2_reg, rm2_reg, dy2_reg;
    logic          rm_neg_reg;

    logic              wr_en_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic [CHAR_W-1:0] wr_data_reg;

    logic          issue;
    kind_t         issue_kind;
    logic [DW-1:0] op, abs_op;
    logic [AB-1:0] ab_val;
    logic [QW-1:0] sq_next;
    logic [QW:0]   d2_next;
    logic          hit;
    logic          last_col, last_row;

    always_comb
    begin
        logic [DW-1:0] one, cx_ext, cy_ext, r_ext;
        one    = DW'(1) << FRAC_BITS;
        cx_ext = {{(DW-COORD_W){cmd_reg.cx[COORD_W-1]}}, cmd_reg.cx};
        cy_ext = {{(DW-COORD_W){cmd_reg.cy[COORD_W-1]}}, cmd_reg.cy};
        r_ext  = {{(DW-COORD_W){cmd_reg.r[COORD_W-1]}}, cmd_reg.r};
        issue      = 1'b0;
        issue_kind = K_CELL;
        op         = (DW'(col_reg) << FRAC_BITS) - cx_ext;
        case (state_reg)
            S_R2:
            begin
                issue      = 1'b1;
                issue_kind = K_R2;
                op         = r_ext;
            end
            S_RM2:
            begin
                issue      = 1'b1;
                issue_kind = K_RM2;
                op         = r_ext - one;
            end
            S_ROW:
            begin
                issue      = 1'b1;
                issue_kind = K_DY;
                op         = (DW'(row_reg) << FRAC_BITS) - cy_ext;
            end
            S_CELLS:
            begin
                issue      = 1'b1;
                issue_kind = K_CELL;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
        abs_op  = op[DW-1] ? (~op + DW'(1)) : op;
        ab_val  = abs_op[AB-1:0];
        sq_next = QW'(ab_val) * QW'(ab_val);
        d2_next = {1'b0, dy2_reg} + {1'b0, s1_sq_reg};
        hit     = cmd_reg.clear ||
                  ((s2_d2_reg <= {1'b0, r2_reg}) &&
                   (!cmd_reg.outline || rm_neg_reg || (s2_d2_reg > {1'b0, rm2_reg})));
        last_col = ({{(SIZE_W-CW){1'b0}}, col_reg} == cmd_reg.w - SIZE_W'(1));
        last_row = ({{(SIZE_W-CW){1'b0}}, row_reg} == cmd_reg.h - SIZE_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (start)
            cmd_reg <= cmd;
    end

    // Sequencer: draw squares parameters, then per row one setup plus a run of cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            base_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_DRAIN) && !s1_valid_reg && !s2_valid_reg &&
                        !wr_en_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        base_reg  <= '0;
                        state_reg <= cmd.clear ? S_CELLS : S_R2;
                    end
                end
                S_R2:  state_reg <= S_RM2;
                S_RM2: state_reg <= S_ROW;
                S_ROW: state_reg <= S_CELLS;
                S_CELLS:
                begin
                    if (last_col)
                    begin
                        col_reg <= '0;
                        if (last_row)
                            state_reg <= S_DRAIN;
                        else
                        begin
                            row_reg   <= row_reg + CW'(1);
                            base_reg  <= base_reg + AW'(MAX_SIDE);
                            state_reg <= cmd_reg.clear ? S_CELLS : S_ROW;
                        end
                    end
                    else
                        col_reg <= col_reg + CW'(1);
                end
                S_DRAIN:
                begin
                    if (!s1_valid_reg && !s2_valid_reg && !wr_en_reg)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            wr_en_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg && (s1_kind_reg == K_CELL);
            wr_en_reg    <= s2_valid_reg && hit;
        end
    end

    // Parameter squares land in their registers in issue order, ahead of their cells
    always_ff @(posedge clk)
    begin
        s1_kind_reg <= issue_kind;
        s1_sq_reg   <= sq_next;
        s1_addr_reg <= base_reg + AW'(col_reg);
        if (state_reg == S_RM2)
            rm_neg_reg <= op[DW-1];
        if (s1_valid_reg)
        begin
            case (s1_kind_reg)
                K_R2:    r2_reg  <= s1_sq_reg;
                K_RM2:   rm2_reg <= s1_sq_reg;
                K_DY:    dy2_reg <= s1_sq_reg;
                default: ;
            endcase
        end
        s2_d2_reg   <= d2_next;
        s2_addr_reg <= s1_addr_reg;
        wr_addr_reg <= s2_addr_reg;
        wr_data_reg <= cmd_reg.paint;
    end

    assign done    = done_reg;
    assign wr_en   = wr_en_reg;
    assign wr_addr = wr_addr_reg;
    assign wr_data = wr_data_reg;

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en_reg)
        else $error("canvas write while sweep idle");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("sweep started while busy");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!s1_valid_reg && !s2_valid_reg && !wr_en_reg))
        else $error("sweep done with pipeline occupied");

endmodule

// File: rtl/circle_raster_canvas.sv
// ----------------------------------------------------------------------------
// circle_raster_canvas
// Byte canvas with clear, filled/outline circle draw and single-cell read.
//
//   port     role     handshake        payload
//   req      sink     valid/ready      mode, shape_type, center_x/y, radius,
//                                      paint_char, read_col, read_row
//   rsp      source   valid/ready      status, cell_value
//   apb      slave    psel/penable     canvas_width, canvas_height,
//                                      background_char at 0x0, 0x4, 0x8
//
// The sweep writes one cell per cycle within a row through the single
// write port of the canvas memory. Canvas contents are undefined after reset
// until a clear or draw writes them. A word is taken only while no other is
// in work; a finished result waits in the output register while the next
// word is taken.
// ----------------------------------------------------------------------------
module circle_raster_canvas
    import crcv_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    crcv_req_if.sink              req,
    crcv_rsp_if.source            rsp
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE, ST_SWEEP, ST_READ, ST_DONE
    } state_t;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [CHAR_W-1:0] bg_reg;

    state_t            state_reg;
    status_t           res_status_reg;
    logic [CHAR_W-1:0] res_value_reg;
    logic              rsp_valid_reg;
    status_t           rsp_status_reg;
    logic [CHAR_W-1:0] rsp_value_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic [SIZE_W-1:0]    eff_w, eff_h;
    logic                 accept, circle_ok, read_in, start, sweep_done;
    sweep_cmd_t           cmd;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [CHAR_W-1:0]    rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [CHAR_W-1:0]    wr_data;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:      prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT:     prdata = APB_DATA_W'(height_reg);
            REG_BACKGROUND: prdata = APB_DATA_W'(bg_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            bg_reg     <= BG_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_WIDTH:      width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:     height_reg <= pwdata[SIZE_W-1:0];
                REG_BACKGROUND: bg_reg     <= pwdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        eff_w     = eff_side(width_reg, MAX_SIDE);
        eff_h     = eff_side(height_reg, MAX_SIDE);
        accept    = req.valid && req.ready;
        circle_ok = !req.radius[COORD_W-1] && (req.radius != '0) &&
                    ((req.shape_type == SHAPE_OUTLINE) || (req.shape_type == SHAPE_FILLED));
        read_in   = (SIZE_W'(req.read_col) < eff_w) && (SIZE_W'(req.read_row) < eff_h);
        start     = accept && ((req.mode == MODE_CLEAR) ||
                               ((req.mode == MODE_DRAW) && circle_ok));
        rd_en     = accept && (req.mode == MODE_READ) && read_in;
        rd_addr   = AW'(req.read_row) * AW'(MAX_SIDE) + AW'(req.read_col);

        cmd.clear   = (req.mode == MODE_CLEAR);
        cmd.outline = (req.shape_type == SHAPE_OUTLINE);
        cmd.cx      = req.center_x;
        cmd.cy      = req.center_y;
        cmd.r       = req.radius;
        cmd.paint   = (req.mode == MODE_CLEAR) ? bg_reg : req.paint_char;
        cmd.w       = eff_w;
        cmd.h       = eff_h;
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.cell_value = rsp_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_status_reg <= STAT_OK;
            res_value_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= STAT_OK;
            rsp_value_reg  <= '0;
        end
        else
        begin
            // drop the word once taken, unless a new result reloads it this cycle
            if (rsp_valid_reg && rsp.ready && (state_reg != ST_DONE))
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        res_value_reg <= '0;
                        case (req.mode)
                            MODE_CLEAR:
                            begin
                                res_status_reg <= STAT_OK;
                                state_reg      <= ST_SWEEP;
                            end
                            MODE_DRAW:
                            begin
                                res_status_reg <= circle_ok ? STAT_OK : STAT_BAD_CIRCLE;
                                state_reg      <= circle_ok ? ST_SWEEP : ST_DONE;
                            end
                            MODE_READ:
                            begin
                                res_status_reg <= read_in ? STAT_OK : STAT_OUTSIDE;
                                state_reg      <= read_in ? ST_READ : ST_DONE;
                            end
                            default:
                            begin
                                res_status_reg <= STAT_OK;
                                state_reg      <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SWEEP:
                begin
                    if (sweep_done)
                        state_reg <= ST_DONE;
                end
                ST_READ:
                begin
                    res_value_reg <= rd_data;
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    // hold the result until the output register frees up
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= res_status_reg;
                        rsp_value_reg  <= res_value_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    crcv_sweep #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .done    (sweep_done),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    crcv_canvas_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_done |-> (state_reg == ST_SWEEP))
        else $error("sweep done outside sweep state");

    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_READ))
        else $error("canvas read not followed by read state");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready))
        |=> (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished result not loaded");

endmodule

// File: bench/circle_raster_canvas_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_canvas_test
// Self-checking bench for the circle raster canvas. A table of directed words
// covers reset values, canvas size limits, bad circles, outside reads and
// small outlines. Random phases then clear, draw and read back small canvases.
// Results match table values or an in-bench canvas predictor. Both streams
// idle at random; APB registers are rewritten and read back between phases.
// ----------------------------------------------------------------------------
module circle_raster_canvas_test;
    import crcv_pkg::*;

    localparam int SIDE           = MAX_SIDE_DEF;
    localparam int ONE            = 1 << FRAC_BITS_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int QUIET_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 8;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [CHAR_W-1:0]         shape;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] r;
        logic [CHAR_W-1:0]         paint;
        logic [POS_W-1:0]          col;
        logic [POS_W-1:0]          row;
    } canvas_word_t;

    typedef struct packed {
        status_t           status;
        logic [CHAR_W-1:0] cell_byte;
    } cell_result_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [REG_IDX_W-1:0]  reg_idx;
        logic [APB_DATA_W-1:0] value;
        canvas_word_t          word;
        bit                    typed;
        cell_result_t          want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    crcv_req_if req_bus ();
    crcv_rsp_if rsp_bus ();

    circle_raster_canvas uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_bus),
        .rsp     (rsp_bus)
    );

    always #5 clk = ~clk;

    // Predicted canvas and register copies
    logic [CHAR_W-1:0] canvas_img   [SIDE*SIDE];
    bit                cell_written [SIDE*SIDE];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [CHAR_W-1:0] bg_reg;

    cell_result_t pending_results [$];
    stim_row_t    dir_rows [$];

    int fail_count    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int burst_left    = 0;
    int holds_asked   = 0;
    int words_by_mode [4];

    function automatic int side_in_use(logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > SIDE)
            return SIDE;
        return int'(v);
    endfunction

    // Apply one word to the predicted canvas and return the result it gives
    function automatic cell_result_t apply_canvas_op(canvas_word_t word);
        cell_result_t res;
        int           w;
        int           h;
        longint       r;
        longint       rm;
        longint       r2;
        longint       rm2;
        longint       dx;
        longint       dy;
        longint       d2;
        bit           outline;
        res.status    = STAT_OK;
        res.cell_byte = '0;
        w = side_in_use(width_reg);
        h = side_in_use(height_reg);
        if (word.mode == MODE_CLEAR) begin
            for (int row = 0; row < h; row++)
                for (int col = 0; col < w; col++) begin
                    canvas_img[row*SIDE+col]   = bg_reg;
                    cell_written[row*SIDE+col] = 1'b1;
                end
        end
        else if (word.mode == MODE_DRAW) begin
            r = longint'($signed(word.r));
            if (r <= 0 || (word.shape != SHAPE_OUTLINE && word.shape != SHAPE_FILLED)) begin
                res.status = STAT_BAD_CIRCLE;
            end
            else begin
                outline = (word.shape == SHAPE_OUTLINE);
                rm  = r - ONE;
                r2  = r * r;
                rm2 = (rm >= 0) ? rm * rm : 0;
                for (int row = 0; row < h; row++) begin
                    dy = longint'(row) * ONE - longint'($signed(word.cy));
                    for (int col = 0; col < w; col++) begin
                        dx = longint'(col) * ONE - longint'($signed(word.cx));
                        d2 = dx * dx + dy * dy;
                        if (d2 <= r2 && (!outline || rm < 0 || d2 > rm2)) begin
                            canvas_img[row*SIDE+col]   = word.paint;
                            cell_written[row*SIDE+col] = 1'b1;
                        end
                    end
                end
            end
        end
        else if (word.mode == MODE_READ) begin
            if (int'(word.col) >= w || int'(word.row) >= h)
                res.status = STAT_OUTSIDE;
            else
                res.cell_byte = canvas_img[int'(word.row)*SIDE+int'(word.col)];
        end
        return res;
    endfunction

    function automatic canvas_word_t plain_word(logic [MODE_W-1:0] mode);
        canvas_word_t word;
        word      = '0;
        word.mode = mode;
        return word;
    endfunction

    function automatic canvas_word_t draw_word(logic [CHAR_W-1:0] shape, int cx, int cy,
                                               int r, logic [CHAR_W-1:0] paint);
        canvas_word_t word;
        word       = '0;
        word.mode  = MODE_DRAW;
        word.shape = shape;
        word.cx    = COORD_W'(cx);
        word.cy    = COORD_W'(cy);
        word.r     = COORD_W'(r);
        word.paint = paint;
        return word;
    endfunction

    function automatic canvas_word_t read_word(int col, int row);
        canvas_word_t word;
        word      = '0;
        word.mode = MODE_READ;
        word.col  = POS_W'(col);
        word.row  = POS_W'(row);
        return word;
    endfunction

    function automatic canvas_word_t rand_word();
        canvas_word_t word;
        word.mode  = MODE_W'($urandom);
        word.shape = CHAR_W'($urandom);
        word.cx    = COORD_W'($urandom);
        word.cy    = COORD_W'($urandom);
        word.r     = COORD_W'($urandom);
        word.paint = CHAR_W'($urandom);
        word.col   = POS_W'($urandom);
        word.row   = POS_W'($urandom);
        return word;
    endfunction

    function automatic stim_row_t word_row(canvas_word_t word);
        stim_row_t sr;
        sr      = '0;
        sr.kind = ROW_WORD;
        sr.word = word;
        return sr;
    endfunction

    function automatic stim_row_t checked_row(canvas_word_t word, status_t status,
                                              int byte_val);
        stim_row_t sr;
        sr                = word_row(word);
        sr.typed          = 1'b1;
        sr.want.status    = status;
        sr.want.cell_byte = CHAR_W'(byte_val);
        return sr;
    endfunction

    function automatic stim_row_t reg_row(logic [REG_IDX_W-1:0] idx, int value);
        stim_row_t sr;
        sr         = '0;
        sr.kind    = ROW_REG;
        sr.reg_idx = idx;
        sr.value   = APB_DATA_W'(value);
        return sr;
    endfunction

    // Offer one word in bursts with random gaps; predict it once accepted
    task automatic push_word(input canvas_word_t word, input bit typed,
                             input cell_result_t want);
        cell_result_t predicted;
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= word.mode;
        req_bus.shape_type <= word.shape;
        req_bus.center_x   <= word.cx;
        req_bus.center_y   <= word.cy;
        req_bus.radius     <= word.r;
        req_bus.paint_char <= word.paint;
        req_bus.read_col   <= word.col;
        req_bus.read_row   <= word.row;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        burst_left--;
        predicted = apply_canvas_op(word);
        pending_results.push_back(typed ? want : predicted);
        words_by_mode[word.mode]++;
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle();
        req_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write, then read the register back
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] kept;
        kept = (idx == REG_BACKGROUND) ? (value & 32'h0000_00FF) : (value & 32'h0000_01FF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_WIDTH:      width_reg  = kept[SIZE_W-1:0];
            REG_HEIGHT:     height_reg = kept[SIZE_W-1:0];
            REG_BACKGROUND: bg_reg     = kept[CHAR_W-1:0];
            default:        ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== kept) begin
            $error("prdata: expected %0h, got %0h", kept, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    // Result side: check accepted words, stall on a pattern of its own
    initial begin
        int           hold_left;
        int           style_left;
        int           style;
        int           holds_served;
        cell_result_t want;
        hold_left    = 0;
        style_left   = 0;
        style        = 0;
        holds_served = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result with none expected: status %0d, cell_value %0d",
                           rsp_bus.status, rsp_bus.cell_value);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                        fail_count++;
                    end
                    if (rsp_bus.cell_value !== want.cell_byte) begin
                        $error("cell_value: expected %0d, got %0d",
                               want.cell_byte, rsp_bus.cell_value);
                        fail_count++;
                    end
                end
            end
            if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (style_left == 0) begin
                style_left = $urandom_range(16, 96);
                style      = $urandom_range(0, 2);
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (style == 0)
                rsp_bus.ready <= 1'b1;
            else if (style == 1)
                rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            else
                rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("circle_raster_canvas test failed");
                $finish;
            end
        end
    end

    initial begin
        canvas_word_t          word;
        int                    weff;
        int                    heff;
        int                    w_val;
        int                    h_val;
        int                    pick;
        int                    n_words;
        logic [APB_DATA_W-1:0] junk;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.mode       <= '0;
        req_bus.shape_type <= '0;
        req_bus.center_x   <= '0;
        req_bus.center_y   <= '0;
        req_bus.radius     <= '0;
        req_bus.paint_char <= '0;
        req_bus.read_col   <= '0;
        req_bus.read_row   <= '0;
        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        bg_reg     = BG_RST;
        foreach (words_by_mode[m])
            words_by_mode[m] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            // full 256 x 256 canvas straight out of reset
            checked_row(plain_word(MODE_CLEAR), STAT_OK, 0),
            checked_row(read_word(0, 0), STAT_OK, 32),
            checked_row(read_word(255, 255), STAT_OK, 32),
            checked_row(draw_word(SHAPE_FILLED, 128*ONE, 128*ONE, 262143, 8'hFF),
                        STAT_OK, 0),
            checked_row(read_word(0, 255), STAT_OK, 8'hFF),
            reg_row(REG_WIDTH, 4),
            reg_row(REG_HEIGHT, 3),
            reg_row(REG_BACKGROUND, 0),
            checked_row(plain_word(MODE_CLEAR), STAT_OK, 0),
            checked_row(read_word(3, 2), STAT_OK, 0),
            checked_row(read_word(4, 0), STAT_OUTSIDE, 0),
            checked_row(read_word(0, 3), STAT_OUTSIDE, 0),
            checked_row(draw_word(8'h00, ONE, ONE, ONE, 8'h58), STAT_BAD_CIRCLE, 0),
            checked_row(draw_word(SHAPE_FILLED, ONE, ONE, 0, 8'h58), STAT_BAD_CIRCLE, 0),
            checked_row(draw_word(SHAPE_OUTLINE, ONE, ONE, -262144, 8'h58),
                        STAT_BAD_CIRCLE, 0),
            checked_row(plain_word(MODE_UNUSED), STAT_OK, 0),
            // outline of radius exactly one leaves the centre cell alone
            word_row(draw_word(SHAPE_OUTLINE, ONE, ONE, ONE, 8'h58)),
            word_row(read_word(1, 1)),
            word_row(read_word(2, 1)),
            // outline below radius one paints the centre too
            word_row(draw_word(SHAPE_OUTLINE, 2*ONE, ONE, ONE/2, 8'h6F)),
            word_row(read_word(2, 1)),
            word_row(draw_word(SHAPE_FILLED, 262143, -262144, 262143, 8'h5A)),
            reg_row(REG_WIDTH, 0),
            reg_row(REG_HEIGHT, 0),
            checked_row(plain_word(MODE_CLEAR), STAT_OK, 0),
            checked_row(read_word(0, 0), STAT_OK, 0),
            checked_row(read_word(1, 0), STAT_OUTSIDE, 0),
            reg_row(REG_WIDTH, 511),
            reg_row(REG_HEIGHT, 1),
            reg_row(REG_BACKGROUND, 255),
            checked_row(plain_word(MODE_CLEAR), STAT_OK, 0),
            word_row(draw_word(SHAPE_OUTLINE, 100*ONE + ONE/2, 0, 3*ONE + ONE/4, 8'h23)),
            word_row(read_word(98, 0)),
            word_row(read_word(100, 0)),
            checked_row(read_word(255, 0), STAT_OK, 255)
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                5: begin w_val = 300; h_val = 2; end
                6: begin w_val = 3;   h_val = 0; end
                default: begin
                    w_val = $urandom_range(1, 16);
                    h_val = $urandom_range(1, 16);
                end
            endcase
            junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FE00) : '0;
            write_reg(REG_WIDTH, APB_DATA_W'(w_val) | junk);
            write_reg(REG_HEIGHT, APB_DATA_W'(h_val));
            junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FF00) : '0;
            write_reg(REG_BACKGROUND, APB_DATA_W'($urandom_range(0, 255)) | junk);
            weff = side_in_use(width_reg);
            heff = side_in_use(height_reg);

            push_word(plain_word(MODE_CLEAR), 1'b0, '0);

            // hold the result side long enough for the block to back up
            if (ph == 2) begin
                holds_asked++;
                for (int k = 0; k < 4; k++)
                    push_word(read_word($urandom_range(0, weff-1),
                                        $urandom_range(0, heff-1)), 1'b0, '0);
            end

            n_words = $urandom_range(6, 10);
            for (int k = 0; k < n_words; k++) begin
                word = rand_word();
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    word.mode  = MODE_DRAW;
                    word.shape = $urandom_range(0, 1) ? SHAPE_FILLED : SHAPE_OUTLINE;
                    if ($urandom_range(0, 7) != 0) begin
                        word.cx = COORD_W'(int'($urandom_range(0, (weff+4)*ONE)) - 2*ONE);
                        word.cy = COORD_W'(int'($urandom_range(0, (heff+4)*ONE)) - 2*ONE);
                        word.r  = COORD_W'($urandom_range(1, ((weff > heff ? weff : heff)
                                                              / 2 + 2) * ONE));
                    end
                end
                else if (pick < 75) begin
                    word.mode = MODE_READ;
                    word.col  = POS_W'($urandom_range(0, weff-1));
                    word.row  = POS_W'($urandom_range(0, heff-1));
                end
                else if (pick < 85)
                    word.mode = MODE_READ;
                else if (pick < 95) begin
                    word.mode = MODE_DRAW;
                    if ($urandom_range(0, 1))
                        word.r = COORD_W'(-int'($urandom_range(0, 262144)));
                    else if (word.shape == SHAPE_OUTLINE || word.shape == SHAPE_FILLED)
                        word.shape = ~word.shape;
                end
                else
                    word.mode = MODE_UNUSED;
                // steer clear of cells nothing has written yet
                if (word.mode == MODE_READ && int'(word.col) < weff && int'(word.row) < heff
                    && !cell_written[int'(word.row)*SIDE+int'(word.col)]) begin
                    if (weff < SIDE)
                        word.col = POS_W'(weff);
                    else if (heff < SIDE)
                        word.row = POS_W'(heff);
                    else
                        word.mode = MODE_CLEAR;
                end
                push_word(word, 1'b0, '0);
            end
        end

        settle();
        $display("Run covered %0d clears, %0d draws, %0d reads and %0d unused-mode words,",
                 words_by_mode[MODE_CLEAR], words_by_mode[MODE_DRAW],
                 words_by_mode[MODE_READ], words_by_mode[MODE_UNUSED]);
        $display("  %0d results checked, %0d register writes with read-back.",
                 results_seen, reg_writes);
        if (fail_count == 0)
            $display("circle_raster_canvas test passed");
        else
            $display("circle_raster_canvas test failed");
        $finish;
    end

endmodule
